### rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, masked while reset is high
`define SED_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds around reset
`define SED_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sed_pkg.sv
// types and constants of the scaled euclidean distance block
package sed_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_QUOT,
    S_MUL,
    S_ACC,
    S_SQRT,
    S_EMIT
  } state_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CAND = 1'b1;

  localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAXMAG = 32'h8000_0000;

  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 32;

  localparam logic [4:0] DIMS_RESET = 5'd10;
  localparam logic       REG_DIMS   = 1'b0;

endpackage

### rtl/core/scaled_euclidean_distance.sv
// scaled euclidean distance: one shared trial-subtract unit under a small sequencer
// query load: prep, divide and quotient run after accept, then the block is ready again
// candidate element: prep, divide, quotient, multiply, accumulate; on the last dimension
//   in use root and emit follow, result valid and block ready, later while a result waits
// one item at a time; the 48-step divide and 32-step root on the shared unit set the rate
// synchronous active-high reset clears control state; query and scale stores are not cleared
module scaled_euclidean_distance #(
  parameter int MAX_DIM = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // dim[3:0], value[35:4], scale[67:36], zero pad[71:68]
  input  logic        s_tuser,   // cmd
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // distance[31:0], candidate_index[47:32]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DCAP = (MAX_DIM < 16) ? MAX_DIM : 16;

  sed_pkg::state_t state, state_next;

  // control registers
  logic [4:0]  dims;
  logic [63:0] acc;
  logic [15:0] cand_cnt;

  // payload registers
  logic        cmd_r;
  logic [3:0]  dim_r;
  logic [AW-1:0] idx_r;
  logic        neg_r;
  logic [31:0] mag_r;
  logic [31:0] scale_r;
  logic [31:0] q_rd;
  logic [31:0] s_rd;
  logic [31:0] divisor;
  logic [63:0] sh;
  logic [32:0] rem;
  logic [31:0] root;
  logic [5:0]  cnt;
  logic [31:0] dmag;
  logic [63:0] sq;

  logic [31:0] qmem [MAX_DIM];
  logic [31:0] smem [MAX_DIM];

  // input unpacking
  logic        in_cmd;
  logic [3:0]  in_dim;
  logic [31:0] in_value;
  logic [31:0] in_scale;
  logic [AW-1:0] in_idx;
  logic        in_dim_ok;
  logic        accept;

  assign in_cmd    = s_tuser;
  assign in_dim    = s_tdata[3:0];
  assign in_value  = s_tdata[35:4];
  assign in_scale  = s_tdata[67:36];
  assign in_idx    = AW'(in_dim);
  assign in_dim_ok = (32'(in_dim) < MAX_DIM);
  assign s_tready  = (state == sed_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == sed_pkg::REG_DIMS);
  assign prdata = (paddr[2] == sed_pkg::REG_DIMS) ? {27'b0, dims} : 32'b0;

  // active dimension count, clamped
  logic [4:0] dims_act;
  logic [3:0] last_dim;
  always_comb begin
    if (dims == 5'd0) begin
      dims_act = 5'd1;
    end else if (dims > 5'(DCAP)) begin
      dims_act = 5'(DCAP);
    end else begin
      dims_act = dims;
    end
    last_dim = 4'(dims_act - 5'd1);
  end

  // shared trial-subtract unit: divide step or square-root step
  logic [34:0] tr_a, tr_b;
  logic [35:0] tr_diff;
  logic        tr_ge;
  always_comb begin
    if (state == sed_pkg::S_SQRT) begin
      tr_a = {rem, sh[63:62]};
      tr_b = {1'b0, root, 2'b01};
    end else begin
      tr_a = {2'b0, rem[31:0], sh[47]};
      tr_b = {3'b0, divisor};
    end
    tr_diff = {1'b0, tr_a} - {1'b0, tr_b};
    tr_ge   = !tr_diff[35];
  end

  // quotient saturation and sign
  logic [47:0] quo;
  logic [31:0] qmag;
  logic [31:0] qsat;
  always_comb begin
    quo = sh[47:0];
    if (neg_r) begin
      qmag = (quo > 48'(sed_pkg::NEG_MAXMAG)) ? sed_pkg::NEG_MAXMAG : quo[31:0];
      qsat = ~qmag + 32'd1;
    end else begin
      qmag = (quo > 48'(sed_pkg::POS_MAX)) ? sed_pkg::POS_MAX : quo[31:0];
      qsat = qmag;
    end
  end

  // difference to the stored query element, exact in 33 bits
  logic [32:0] dq, dq_neg;
  assign dq     = {q_rd[31], q_rd} - {qsat[31], qsat};
  assign dq_neg = ~dq + 33'd1;

  // accumulator update with saturation; dimension 0 starts a new sum
  logic [64:0] acc_sum;
  logic [63:0] acc_next;
  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, sq};
    if (dim_r == 4'd0) begin
      acc_next = sq;
    end else if (acc_sum[64]) begin
      acc_next = '1;
    end else begin
      acc_next = acc_sum[63:0];
    end
  end

  logic emit_load;
  assign emit_load = (state == sed_pkg::S_EMIT) && (!m_tvalid || m_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sed_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sed_pkg::S_IDLE: begin
        if (accept && in_dim_ok) state_next = sed_pkg::S_PREP;
      end
      sed_pkg::S_PREP: state_next = sed_pkg::S_DIV;
      sed_pkg::S_DIV: begin
        if (cnt == 6'd0) state_next = sed_pkg::S_QUOT;
      end
      sed_pkg::S_QUOT: begin
        state_next = (cmd_r == sed_pkg::CMD_LOAD) ? sed_pkg::S_IDLE : sed_pkg::S_MUL;
      end
      sed_pkg::S_MUL: state_next = sed_pkg::S_ACC;
      sed_pkg::S_ACC: begin
        state_next = (dim_r == last_dim) ? sed_pkg::S_SQRT : sed_pkg::S_IDLE;
      end
      sed_pkg::S_SQRT: begin
        if (cnt == 6'd0) state_next = sed_pkg::S_EMIT;
      end
      sed_pkg::S_EMIT: begin
        if (emit_load) state_next = sed_pkg::S_IDLE;
      end
      default: state_next = sed_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      dims     <= sed_pkg::DIMS_RESET;
      acc      <= '0;
      cand_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) dims <= pwdata[4:0];
      if (state == sed_pkg::S_ACC) acc <= acc_next;
      if (state == sed_pkg::S_QUOT && cmd_r == sed_pkg::CMD_LOAD) begin
        cand_cnt <= '0;
      end else if (emit_load) begin
        cand_cnt <= cand_cnt + 16'd1;
      end
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // query and scale stores
  always_ff @(posedge clk) begin
    if (accept && in_dim_ok) begin
      q_rd <= qmem[in_idx];
      s_rd <= smem[in_idx];
    end
    if (state == sed_pkg::S_QUOT && cmd_r == sed_pkg::CMD_LOAD) begin
      qmem[idx_r] <= qsat;
      smem[idx_r] <= scale_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      dim_r   <= in_dim;
      idx_r   <= in_idx;
      neg_r   <= in_value[31];
      mag_r   <= in_value[31] ? (~in_value + 32'd1) : in_value;
      scale_r <= in_scale;
    end
    if (emit_load) m_tdata <= {cand_cnt, root};
    unique case (state)
      sed_pkg::S_PREP: begin
        if (cmd_r == sed_pkg::CMD_LOAD) begin
          divisor <= (scale_r == 32'd0) ? sed_pkg::ONE_Q16 : scale_r;
        end else begin
          divisor <= (s_rd == 32'd0) ? sed_pkg::ONE_Q16 : s_rd;
        end
        sh  <= {16'b0, mag_r, 16'b0};
        rem <= '0;
        cnt <= 6'(sed_pkg::DIV_STEPS - 1);
      end
      sed_pkg::S_DIV: begin
        rem <= tr_ge ? {1'b0, tr_diff[31:0]} : {1'b0, tr_a[31:0]};
        sh  <= {sh[63:48], sh[46:0], tr_ge};
        cnt <= cnt - 6'd1;
      end
      sed_pkg::S_QUOT: begin
        dmag <= dq[32] ? dq_neg[31:0] : dq[31:0];
      end
      sed_pkg::S_MUL: begin
        sq <= 64'(dmag) * 64'(dmag);
      end
      sed_pkg::S_ACC: begin
        sh   <= acc_next;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'(sed_pkg::SQRT_STEPS - 1);
      end
      sed_pkg::S_SQRT: begin
        rem  <= tr_ge ? tr_diff[32:0] : tr_a[32:0];
        root <= {root[30:0], tr_ge};
        sh   <= {sh[61:0], 2'b00};
        cnt  <= cnt - 6'd1;
      end
      sed_pkg::S_IDLE, sed_pkg::S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/sed_checker.sv
// port-level checker for the scaled euclidean distance block, with its bind
`include "assert_macros.svh"

module sed_checker #(
  parameter int MAX_DIM = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [71:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  logic busy_req;
  assign busy_req = s_tvalid && s_tready && (32'(s_tdata[3:0]) < MAX_DIM);

  // reset leaves the block idle with nothing to deliver
  `SED_ASSERT_NR(a_reset_idle, clk, rst |=> (s_tready && !m_tvalid), "not idle after reset")

  // a request on a valid dimension keeps the block busy for the next cycles
  `SED_ASSERT(a_busy_after_req, clk, rst, busy_req |=> !s_tready ##1 !s_tready, "ready too early")

  // a result only appears out of a busy cycle
  `SED_ASSERT(a_result_from_work, clk, rst, $rose(m_tvalid) |-> !$past(s_tready), "spurious result")

  // a stalled result holds
  `SED_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stall lost")

endmodule

bind scaled_euclidean_distance sed_checker #(.MAX_DIM(MAX_DIM)) u_sed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the scaled euclidean distance block
module tb_top;

  localparam int MAX_DIM      = 16;
  localparam int N_DIRECTED   = 25;
  localparam int N_PHASES     = 9;
  localparam int PHASE_REQS   = 90;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  dim;
    logic [31:0] value;
    logic [31:0] scale;
  } elem_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [15:0] index;
  } dist_t;

  typedef struct packed {
    elem_t e;
    logic  pinned;
    dist_t res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // dim[3:0], value[35:4], scale[67:36], zero pad[71:68]
  logic        s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // distance[31:0], candidate_index[47:32]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  scaled_euclidean_distance #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the block state
  logic [31:0] qnorm_mirror [MAX_DIM];
  logic [31:0] scale_mirror [MAX_DIM];
  logic [63:0] sq_sum;
  logic [15:0] cand_ord;
  logic [4:0]  dims_cfg;

  dist_t pending_dist [$];
  int    errors;
  bit    idle_on;
  row_t  dir_rows [N_DIRECTED];
  logic [4:0] phase_dims [N_PHASES] = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd5, 5'd12, 5'd16,
                                        5'd3};

  function automatic elem_t make_elem(input logic cmd, input logic [3:0] dim,
                                      input logic [31:0] value, input logic [31:0] scale);
    elem_t e;
    e.cmd   = cmd;
    e.dim   = dim;
    e.value = value;
    e.scale = scale;
    return e;
  endfunction

  // (|v| << 16) / s toward zero, sign restored, saturated to signed 32 bits
  function automatic logic [31:0] norm_q16(input logic [31:0] v, input logic [31:0] s);
    logic [63:0] mag, quo, sd;
    sd  = (s == '0) ? {32'd0, sed_pkg::ONE_Q16} : {32'd0, s};
    mag = v[31] ? 64'd0 - {{32{1'b1}}, v} : {32'd0, v};
    quo = (mag << 16) / sd;
    if (v[31]) begin
      if (quo > {32'd0, sed_pkg::NEG_MAXMAG}) quo = {32'd0, sed_pkg::NEG_MAXMAG};
      return 32'd0 - quo[31:0];
    end
    if (quo > {32'd0, sed_pkg::POS_MAX}) quo = {32'd0, sed_pkg::POS_MAX};
    return quo[31:0];
  endfunction

  function automatic int active_dims();
    int d;
    d = int'(dims_cfg);
    if (d == 0) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom;
      2: return $urandom_range(1, 255);
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  task automatic step_distance(input elem_t e, output bit got, output dist_t r);
    logic [31:0] cand_n;
    logic [33:0] diff;
    logic [33:0] neg_diff;
    logic [31:0] mag;
    logic [63:0] sq, root, trial;
    logic [64:0] wide;
    got = 1'b0;
    r   = '0;
    if (e.cmd == sed_pkg::CMD_LOAD) begin
      scale_mirror[e.dim] = e.scale;
      qnorm_mirror[e.dim] = norm_q16(e.value, e.scale);
      cand_ord = '0;
    end else begin
      cand_n   = norm_q16(e.value, scale_mirror[e.dim]);
      diff     = {{2{qnorm_mirror[e.dim][31]}}, qnorm_mirror[e.dim]}
                 - {{2{cand_n[31]}}, cand_n};
      neg_diff = 34'd0 - diff;
      mag      = diff[33] ? neg_diff[31:0] : diff[31:0];
      sq       = {32'd0, mag} * {32'd0, mag};
      wide     = {1'b0, sq_sum} + {1'b0, sq};
      // dim 0 starts a new sum, otherwise saturate at all ones
      if (e.dim == 4'd0) sq_sum = sq;
      else sq_sum = wide[64] ? '1 : wide[63:0];
      if (int'(e.dim) == active_dims() - 1) begin
        root = '0;
        for (int b = 31; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= sq_sum) root = trial;
        end
        got        = 1'b1;
        r.distance = root[31:0];
        r.index    = cand_ord;
        cand_ord   = cand_ord + 16'd1;
      end
    end
  endtask

  // drive one request, wait for accept, then queue what it should produce
  task automatic issue_request(input elem_t e, input bit pinned, input dist_t typed);
    int    gap;
    bit    got;
    dist_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= e.cmd;
    s_tdata  <= {4'd0, e.scale, e.value, e.dim};
    do @(posedge clk); while (!s_tready);
    step_distance(e, got, r);
    if (got) pending_dist.push_back(pinned ? typed : r);
  endtask

  // sender holds off until every result is back and the block has settled
  task automatic drain_all();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input logic [4:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sed_pkg::REG_DIMS, 2'b00};
    pwdata  <= {27'd0, d};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dims_cfg = d;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input int quota);
    int sent, n, pick, last_extra;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        for (int d = 0; d < MAX_DIM; d++)
          issue_request(make_elem(sed_pkg::CMD_LOAD, 4'(d), pick_value(), pick_scale()),
                        1'b0, '0);
        sent += MAX_DIM;
      end else if (pick < 16) begin
        n = $urandom_range(1, 4);
        repeat (n)
          issue_request(make_elem(sed_pkg::CMD_LOAD, 4'($urandom_range(0, MAX_DIM - 1)),
                                  pick_value(), pick_scale()), 1'b0, '0);
        sent += n;
      end else if (pick < 90) begin
        n = active_dims();
        for (int d = 0; d < n; d++)
          issue_request(make_elem(sed_pkg::CMD_CAND, 4'(d), pick_value(), $urandom),
                        1'b0, '0);
        sent += n;
        // trailing elements past the last dimension in use
        if (n < MAX_DIM && $urandom_range(0, 4) == 0) begin
          last_extra = $urandom_range(n, MAX_DIM - 1);
          for (int d = n; d <= last_extra; d++)
            issue_request(make_elem(sed_pkg::CMD_CAND, 4'(d), pick_value(), $urandom),
                          1'b0, '0);
          sent += last_extra - n + 1;
        end
      end else begin
        issue_request(make_elem(sed_pkg::CMD_CAND, 4'($urandom_range(0, MAX_DIM - 1)),
                                pick_value(), $urandom), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("FAIL scaled_euclidean_distance");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    dist_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dist.size() == 0) begin
        $display("%0t: unexpected result distance %h index %0d", $time, m_tdata[31:0],
                 m_tdata[47:32]);
        errors++;
      end else begin
        want = pending_dist.pop_front();
        if (m_tdata[31:0] !== want.distance) begin
          $display("%0t: distance expected %h actual %h", $time, want.distance, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[47:32] !== want.index) begin
          $display("%0t: candidate index expected %0d actual %0d", $time, want.index,
                   m_tdata[47:32]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    errors   = 0;
    idle_on  = 1'b1;
    sq_sum   = '0;
    cand_ord = '0;
    dims_cfg = sed_pkg::DIMS_RESET;

    // query loads: zero scale, unit scale, saturation both ways, largest scale
    dir_rows[0] = {make_elem(sed_pkg::CMD_LOAD, 4'd0, 32'h7FFF_FFFF, 32'h0000_0000), 1'b0,
                   48'h0};
    dir_rows[1] = {make_elem(sed_pkg::CMD_LOAD, 4'd1, 32'h7FFF_FFFF, 32'h0001_0000), 1'b0,
                   48'h0};
    dir_rows[2] = {make_elem(sed_pkg::CMD_LOAD, 4'd2, 32'h7FFF_FFFF, 32'h0000_0001), 1'b0,
                   48'h0};
    dir_rows[3] = {make_elem(sed_pkg::CMD_LOAD, 4'd3, 32'h8000_0000, 32'h0000_0001), 1'b0,
                   48'h0};
    dir_rows[4] = {make_elem(sed_pkg::CMD_LOAD, 4'd4, 32'h8000_0000, 32'hFFFF_FFFF), 1'b0,
                   48'h0};
    dir_rows[5] = {make_elem(sed_pkg::CMD_LOAD, 4'd5, 32'h0000_0000, 32'hFFFF_FFFF), 1'b0,
                   48'h0};
    for (int k = 6; k < 10; k++)
      dir_rows[k] = {make_elem(sed_pkg::CMD_LOAD, 4'(k), 32'h7FFF_FFFF, 32'h0000_0000), 1'b0,
                     48'h0};
    // most negative candidate at every dimension in use, the sum saturates
    for (int k = 0; k < 9; k++)
      dir_rows[10 + k] = {make_elem(sed_pkg::CMD_CAND, 4'(k), 32'h8000_0000, 32'hFFFF_FFFF),
                          1'b0, 48'h0};
    dir_rows[19] = {make_elem(sed_pkg::CMD_CAND, 4'd9, 32'h8000_0000, 32'hFFFF_FFFF), 1'b1,
                    32'hFFFF_FFFF, 16'd0};
    dir_rows[20] = {make_elem(sed_pkg::CMD_CAND, 4'd9, 32'h8000_0000, 32'h0000_0000), 1'b1,
                    32'hFFFF_FFFF, 16'd1};
    // a load restarts the candidate count
    dir_rows[21] = {make_elem(sed_pkg::CMD_LOAD, 4'd9, 32'h0000_0000, 32'h0000_0000), 1'b0,
                    48'h0};
    dir_rows[22] = {make_elem(sed_pkg::CMD_CAND, 4'd9, 32'h0000_0000, 32'h0000_0000), 1'b1,
                    32'hFFFF_FFFF, 16'd0};
    // dim 0 clears the sum, then a difference of exactly 1.0
    dir_rows[23] = {make_elem(sed_pkg::CMD_CAND, 4'd0, 32'h7FFF_FFFF, 32'h0000_0000), 1'b0,
                    48'h0};
    dir_rows[24] = {make_elem(sed_pkg::CMD_CAND, 4'd9, 32'h0001_0000, 32'h0000_0000), 1'b1,
                    32'h0001_0000, 16'd1};

    phase_dims[6] = 5'($urandom_range(2, 15));
    phase_dims[8] = 5'($urandom_range(0, 31));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      issue_request(dir_rows[i].e, dir_rows[i].pinned, dir_rows[i].res);

    // every store entry gets written before random candidates read it
    for (int d = 0; d < MAX_DIM; d++)
      issue_request(make_elem(sed_pkg::CMD_LOAD, 4'(d), pick_value(), pick_scale()), 1'b0,
                    '0);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_all();
      idle_on = (p != 2);
      write_dims(phase_dims[p]);
      run_phase(PHASE_REQS);
    end

    drain_all();
    if (errors == 0) begin
      $display("PASS scaled_euclidean_distance");
    end else begin
      $display("FAIL scaled_euclidean_distance");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sed_pkg.sv
rtl/core/scaled_euclidean_distance.sv
rtl/core/sed_checker.sv
bench/tb_top.sv
